// ----- rtl/core/mrt_pkg.sv -----
// Shared types, codes and constants for the protection region table.
// Used by every module under rtl/core but mrt_ram; depends on nothing else.

package mrt_pkg;

    // Field widths of the command and result beats.
    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 4;
    localparam int CNT_W     = 5;
    localparam int SHIFT_W   = 5;

    // Defaults handed to the top-level parameters.
    localparam int REGION_SLOTS_DEF = 16;
    localparam int ADDR_WIDTH_DEF   = 32;

    // Depth of the queue between the front and the back part.
    localparam int QDEPTH = 2;

    // Configuration register indices and reset values.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POW2_REQUIRED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_SHIFT   = 2'd2;
    localparam logic [CNT_W-1:0]     REGION_LIMIT_RST  = 5'd16;

    // Command codes as they arrive on the port.
    localparam logic [CMD_W-1:0] CMD_MAP     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNMAP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PROTECT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    // Decoded operation carried through the queue.
    typedef enum logic [2:0] {
        OP_MAP,
        OP_UNMAP,
        OP_PROTECT,
        OP_QUERY,
        OP_CLEAR,
        OP_BAD
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVAL    = 3'd1,
        ST_NORES    = 3'd2,
        ST_MAPPED   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Live configuration.
    typedef struct packed {
        logic [CNT_W-1:0]   region_limit;
        logic               pow2_required;
        logic [SHIFT_W-1:0] align_shift;
    } t_cfg;

    // One classified command. Addresses and sizes are already masked to the
    // address width; delta is the physical base minus the virtual base.
    typedef struct packed {
        t_op                op;
        logic               arg_bad;
        logic [FIELD_W-1:0] addr;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] delta;
        logic [FIELD_W-1:0] flags;
    } t_item;

    // Mask of the low address bits that the table works on.
    function automatic logic [FIELD_W-1:0] addr_mask(input int addr_width);
        logic [FIELD_W-1:0] mask;
        mask = '1;
        if (addr_width < FIELD_W) begin
            mask = {FIELD_W{1'b1}} >> (FIELD_W - addr_width);
        end
        return mask;
    endfunction

endpackage

// ----- rtl/core/mpu_region_table.sv -----
// A result strobe follows each accepted start beat through the queue, the
// command register and the result registers; a query that hits also passes
// S_QRY, where it reads the translation RAMs. The back sequencer handles one
// command at a time; a 2-entry queue in front takes new commands meanwhile.
// Reset: the table is empty and configuration takes its defaults at once; the
// payload memories need no clearing pass. Results cannot be stalled.

module mpu_region_table import mrt_pkg::*; #(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Command channel.
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [FIELD_W-1:0]    i_virt_addr,
    input  logic [FIELD_W-1:0]    i_phys_addr,
    input  logic [FIELD_W-1:0]    i_region_size,
    input  logic [FIELD_W-1:0]    i_region_flags,
    // Result channel.
    output logic                  o_done,
    output logic [STATUS_W-1:0]   o_status,
    output logic [SLOT_W-1:0]     o_slot_index,
    output logic [FIELD_W-1:0]    o_phys_result,
    output logic [FIELD_W-1:0]    o_flags_result
);

    t_cfg  r_cfg;
    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; unknown indices are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_limit  <= REGION_LIMIT_RST;
            r_cfg.pow2_required <= 1'b0;
            r_cfg.align_shift   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REGION_LIMIT:  r_cfg.region_limit  <= CNT_W'(i_cfg_data);
                CFG_POW2_REQUIRED: r_cfg.pow2_required <= i_cfg_data[0];
                CFG_ALIGN_SHIFT:   r_cfg.align_shift   <= SHIFT_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    mrt_front #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_virt_addr    (i_virt_addr),
        .i_phys_addr    (i_phys_addr),
        .i_region_size  (i_region_size),
        .i_region_flags (i_region_flags),
        .o_head         (w_head),
        .o_head_valid   (w_head_valid),
        .i_pop          (w_pop)
    );

    mrt_back #(
        .REGION_SLOTS (REGION_SLOTS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_head         (w_head),
        .i_head_valid   (w_head_valid),
        .o_pop          (w_pop),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_slot_index   (o_slot_index),
        .o_phys_result  (o_phys_result),
        .o_flags_result (o_flags_result)
    );

    // Every command passes through S_ACT after S_IDLE in the back part, so result strobes never come back to back.
    a_no_back_to_back_done: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done
    ) else $error("result strobes in two consecutive cycles");

    // A failed command reports no slot, address or flags.
    a_fail_fields_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |->
            ((o_slot_index == '0) && (o_phys_result == '0) && (o_flags_result == '0))
    ) else $error("failed command carries non-zero result fields");

    // The queue only fills up after a command beat was taken.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && !o_busy)
    ) else $error("busy rose without an accepted command");

endmodule

// ----- rtl/core/mrt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by the back part for per-slot payload.

module mrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/mrt_front.sv -----
// Front part: accepts commands, decodes and checks their arguments, and
// queues them for the back part. Depends on mrt_pkg.

module mrt_front import mrt_pkg::*; #(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [FIELD_W-1:0] i_virt_addr,
    input  logic [FIELD_W-1:0] i_phys_addr,
    input  logic [FIELD_W-1:0] i_region_size,
    input  logic [FIELD_W-1:0] i_region_flags,
    output t_item              o_head,
    output logic               o_head_valid,
    input  logic               i_pop
);

    localparam logic [FIELD_W-1:0] AMASK = addr_mask(ADDR_WIDTH);
    localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_item              r_q [QDEPTH];
    logic [QPW-1:0]     r_wptr;
    logic [QPW-1:0]     r_rptr;
    logic [QCW-1:0]     r_cnt;

    logic               w_push;
    t_item              w_item;
    logic [FIELD_W-1:0] w_addr;
    logic [FIELD_W-1:0] w_phys;
    logic [FIELD_W-1:0] w_size;
    logic [FIELD_W-1:0] w_align_mask;
    logic               w_pow2_bad;
    logic               w_too_small;
    logic               w_misaligned;

    assign o_busy       = (r_cnt == QCW'(QDEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rptr];
    assign w_push       = i_start && !o_busy;

    // Argument checks that depend only on the beat and the configuration.
    always_comb begin
        w_addr       = i_virt_addr & AMASK;
        w_phys       = i_phys_addr & AMASK;
        w_size       = i_region_size & AMASK;
        w_align_mask = ~({FIELD_W{1'b1}} << i_cfg.align_shift);
        w_pow2_bad   = i_cfg.pow2_required &&
                       ((w_size == '0) || ((w_size & (w_size - 1'b1)) != '0));
        w_too_small  = ((w_size >> i_cfg.align_shift) == '0);
        w_misaligned = ((w_addr & w_align_mask) != '0) ||
                       ((w_phys & w_align_mask) != '0);

        w_item.arg_bad = w_pow2_bad || w_too_small || w_misaligned;
        w_item.addr    = w_addr;
        w_item.size    = w_size;
        w_item.delta   = (w_phys - w_addr) & AMASK;
        w_item.flags   = i_region_flags;

        case (i_command)
            CMD_MAP:     w_item.op = OP_MAP;
            CMD_UNMAP:   w_item.op = OP_UNMAP;
            CMD_PROTECT: w_item.op = OP_PROTECT;
            CMD_QUERY:   w_item.op = OP_QUERY;
            CMD_CLEAR:   w_item.op = OP_CLEAR;
            default:     w_item.op = OP_BAD;
        endcase
    end

    // Queue storage; entries carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    // Queue pointers and fill level. The depth is a power of two, so the
    // pointers wrap on their own.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/mrt_back.sv -----
// Back part: holds the region table, compares a queued command against all
// slots, applies it and produces the result beat. Depends on mrt_pkg, mrt_ram.

module mrt_back import mrt_pkg::*; #(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  t_item               i_head,
    input  logic                i_head_valid,
    output logic                o_pop,
    output logic                o_done,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_slot_index,
    output logic [FIELD_W-1:0]  o_phys_result,
    output logic [FIELD_W-1:0]  o_flags_result
);

    localparam int SW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
    localparam logic [FIELD_W-1:0] AMASK = addr_mask(ADDR_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACT,
        S_QRY
    } t_state;

    // Table state.
    logic [REGION_SLOTS-1:0] r_valid;
    logic [FIELD_W-1:0]      r_virt [REGION_SLOTS];
    logic [FIELD_W-1:0]      r_size [REGION_SLOTS];
    logic [CNT_W-1:0]        r_count;

    // Command under work and its registered compare results.
    t_item                   r_item;
    logic [REGION_SLOTS-1:0] r_ovl;
    logic [REGION_SLOTS-1:0] r_qhit;
    logic [REGION_SLOTS-1:0] r_exact;

    // Sequencer state and result registers.
    t_state                  r_state;
    logic                    r_done;
    t_status                 r_status;
    logic [SW-1:0]           r_slot;
    logic [FIELD_W-1:0]      r_phys;
    logic [FIELD_W-1:0]      r_flags;

    t_state                  n_state;
    logic                    n_done;
    t_status                 n_status;
    logic [SW-1:0]           n_slot;
    logic [FIELD_W-1:0]      n_phys;
    logic [FIELD_W-1:0]      n_flags;
    logic [CNT_W-1:0]        n_count;

    logic [REGION_SLOTS-1:0] w_ovl;
    logic [REGION_SLOTS-1:0] w_qhit;
    logic [REGION_SLOTS-1:0] w_exact;
    logic [SW-1:0]           w_free_idx;
    logic [SW-1:0]           w_exact_idx;
    logic [SW-1:0]           w_qhit_idx;
    logic                    w_set;
    logic                    w_unset;
    logic                    w_clear_all;
    logic                    w_delta_we;
    logic                    w_flags_we;
    logic [SW-1:0]           w_flags_waddr;
    logic                    w_rd_en;
    logic [FIELD_W-1:0]      w_delta_rd;
    logic [FIELD_W-1:0]      w_flags_rd;

    // Lowest set bit of a slot vector.
    function automatic logic [SW-1:0] first_set(input logic [REGION_SLOTS-1:0] vec);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = SW'(i);
            end
        end
        return idx;
    endfunction

    // Per-slot compares of the queue head against every region. Ends are
    // never formed, so nothing wraps.
    always_comb begin
        logic [FIELD_W-1:0] d_ab;
        logic [FIELD_W-1:0] d_ba;
        logic               ge_ab;
        logic               ge_ba;
        logic               above;
        logic               below;
        for (int i = 0; i < REGION_SLOTS; i++) begin
            ge_ab      = (i_head.addr >= r_virt[i]);
            ge_ba      = (r_virt[i] >= i_head.addr);
            d_ab       = i_head.addr - r_virt[i];
            d_ba       = r_virt[i] - i_head.addr;
            above      = ge_ab && (d_ab >= r_size[i]);
            below      = ge_ba && (d_ba >= i_head.size);
            w_ovl[i]   = r_valid[i] && !(above || below);
            w_qhit[i]  = r_valid[i] && ge_ab && (d_ab < r_size[i]);
            w_exact[i] = r_valid[i] && (i_head.addr == r_virt[i]) &&
                         (i_head.size == r_size[i]);
        end
    end

    assign w_free_idx  = first_set(~r_valid);
    assign w_exact_idx = first_set(r_exact);
    assign w_qhit_idx  = first_set(r_qhit);

    // Sequencer: take a command, act on it, finish a lookup.
    always_comb begin
        n_state       = r_state;
        n_done        = 1'b0;
        n_status      = ST_OK;
        n_slot        = '0;
        n_phys        = '0;
        n_flags       = '0;
        n_count       = r_count;
        o_pop         = 1'b0;
        w_set         = 1'b0;
        w_unset       = 1'b0;
        w_clear_all   = 1'b0;
        w_delta_we    = 1'b0;
        w_flags_we    = 1'b0;
        w_flags_waddr = w_free_idx;
        w_rd_en       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop   = 1'b1;
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_item.op)
                    OP_MAP: begin
                        if (r_count >= i_cfg.region_limit) begin
                            n_status = ST_NORES;
                        end else if (r_item.arg_bad) begin
                            n_status = ST_INVAL;
                        end else if (|r_ovl) begin
                            n_status = ST_MAPPED;
                        end else if (&r_valid) begin
                            n_status = ST_NORES;
                        end else begin
                            n_slot     = w_free_idx;
                            n_count    = r_count + 1'b1;
                            w_set      = 1'b1;
                            w_delta_we = 1'b1;
                            w_flags_we = 1'b1;
                        end
                    end
                    OP_UNMAP: begin
                        if (|r_exact) begin
                            n_slot  = w_exact_idx;
                            w_unset = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - 1'b1;
                            end
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    OP_PROTECT: begin
                        if (|r_exact) begin
                            n_slot        = w_exact_idx;
                            w_flags_we    = 1'b1;
                            w_flags_waddr = w_exact_idx;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    OP_QUERY: begin
                        if (|r_qhit) begin
                            // Fetch the translation; the result follows.
                            n_done  = 1'b0;
                            n_slot  = w_qhit_idx;
                            w_rd_en = 1'b1;
                            n_state = S_QRY;
                        end else begin
                            n_status = ST_NOTFOUND;
                        end
                    end
                    OP_CLEAR: begin
                        w_clear_all = 1'b1;
                        n_count     = '0;
                    end
                    default: begin
                        n_status = ST_INVAL;
                    end
                endcase
            end
            S_QRY: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_slot  = r_slot;
                n_phys  = (r_item.addr + w_delta_rd) & AMASK;
                n_flags = w_flags_rd;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_count <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_count <= n_count;
            if (w_clear_all) begin
                r_valid <= '0;
            end else if (w_set) begin
                r_valid[w_free_idx] <= 1'b1;
            end else if (w_unset) begin
                r_valid[w_exact_idx] <= 1'b0;
            end
        end
        r_status <= n_status;
        r_slot   <= n_slot;
        r_phys   <= n_phys;
        r_flags  <= n_flags;
    end

    // Payload: region bounds and the command under work.
    always_ff @(posedge i_clk) begin
        if (w_set) begin
            r_virt[w_free_idx] <= r_item.addr;
            r_size[w_free_idx] <= r_item.size;
        end
        if (o_pop) begin
            r_item  <= i_head;
            r_ovl   <= w_ovl;
            r_qhit  <= w_qhit;
            r_exact <= w_exact;
        end
    end

    // Physical-minus-virtual offset of each region.
    mrt_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (REGION_SLOTS)
    ) u_delta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_delta_we),
        .i_wr_addr (w_free_idx),
        .i_wr_data (r_item.delta),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_qhit_idx),
        .o_rd_data (w_delta_rd)
    );

    // Access flags of each region.
    mrt_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (REGION_SLOTS)
    ) u_flags_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_flags_we),
        .i_wr_addr (w_flags_waddr),
        .i_wr_data (r_item.flags),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_qhit_idx),
        .o_rd_data (w_flags_rd)
    );

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_slot_index   = SLOT_W'(r_slot);
    assign o_phys_result  = r_phys;
    assign o_flags_result = r_flags;

endmodule
